/* rtl/chained_hash_table_macros.svh */
// assertion macros used by the checker file of the hash table
`ifndef CHAINED_HASH_TABLE_MACROS_SVH
`define CHAINED_HASH_TABLE_MACROS_SVH

// same-cycle implication, reset-qualified
`define CHT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset-qualified
`define CHT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/cht_pkg.sv */
// shared types and codes of the chained hash table
`default_nettype none

package cht_pkg;

    localparam int KEY_W     = 16;
    localparam int VAL_W     = 32;
    localparam int ENTRY_W   = KEY_W + VAL_W;
    localparam int STATUS_W  = 3;
    localparam int BIDX_W    = 5;
    localparam int CIDX_W    = 3;
    localparam int SQ_W      = 2 * KEY_W;
    localparam int DIGIT_W   = 8;
    localparam int HASH_STEPS = SQ_W / DIGIT_W;
    localparam int HSTEP_W   = $clog2(HASH_STEPS);

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ABSENT   = 3'd4;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_FILL,
        S_DECIDE,
        S_SCAN
    } state_t;

endpackage

`default_nettype wire

/* rtl/cht_hash.sv */
// bucket hash: key squared, reduced modulo the bucket count a byte per cycle
`default_nettype none

module cht_hash #(
    parameter int BUCKETS = 20
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              go,
    input  wire signed [cht_pkg::KEY_W-1:0]  key,
    output logic                             done,
    output logic [$clog2(BUCKETS)-1:0]       bucket
);
    import cht_pkg::*;

    localparam int BKT_W = $clog2(BUCKETS);
    localparam int RW    = BKT_W + 1;

    logic [KEY_W-1:0]   mag;
    logic [SQ_W-1:0]    sq_reg;
    logic [BKT_W-1:0]   rem_reg;
    logic [HSTEP_W-1:0] step_reg;
    logic               run_reg;
    logic               done_reg;

    // restoring reduction of one byte into the running remainder
    function automatic logic [BKT_W-1:0] reduce_digit(
        input logic [BKT_W-1:0]   r_in,
        input logic [DIGIT_W-1:0] digit
    );
        logic [RW-1:0] r;
        r = RW'(r_in);
        for (int i = DIGIT_W - 1; i >= 0; i--) begin
            r = {r[RW-2:0], digit[i]};
            if (r >= RW'(BUCKETS))
            begin
                r = r - RW'(BUCKETS);
            end
        end
        return r[BKT_W-1:0];
    endfunction

    // magnitude of the signed key; the most negative key maps to 0x8000
    assign mag = key[KEY_W-1] ? (~key + KEY_W'(1)) : key;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= run_reg && (step_reg == HSTEP_W'(HASH_STEPS - 1));
            if (go)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + HSTEP_W'(1);
                if (step_reg == HSTEP_W'(HASH_STEPS - 1))
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            sq_reg  <= mag * mag;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            rem_reg <= reduce_digit(rem_reg, sq_reg[SQ_W-1 -: DIGIT_W]);
            sq_reg  <= sq_reg << DIGIT_W;
        end
    end

    assign done   = done_reg;
    assign bucket = rem_reg;

endmodule

`default_nettype wire

/* rtl/chained_hash_table.sv */
// an insert strobes its result once the hash and the fill read are done; a query scans the
// chain up to the match, through the whole fill when absent, not at all when the bucket is empty
// throughput: one item at a time; the next item is taken in the cycle the result strobes,
// so the rate is set by the 4-step hash reduction, the fill read and the chain scan
// reset: after rst_n rises, busy stays high while the fill counts are cleared
// results cannot be stalled: done marks each result for exactly one cycle
`default_nettype none

module chained_hash_table #(
    parameter int BUCKETS     = 20,
    parameter int CHAIN_DEPTH = 8
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  start,
    output logic                                 busy,
    input  wire                                  command,
    input  wire signed [cht_pkg::KEY_W-1:0]      key,
    input  wire signed [cht_pkg::VAL_W-1:0]      value,
    output logic                                 done,
    output logic [cht_pkg::STATUS_W-1:0]         status,
    output logic [cht_pkg::BIDX_W-1:0]           bucket_index,
    output logic [cht_pkg::CIDX_W-1:0]           chain_index
);
    import cht_pkg::*;

    localparam int BKT_W  = $clog2(BUCKETS);
    localparam int FILL_W = $clog2(CHAIN_DEPTH + 1);
    localparam int DEPTH  = BUCKETS * CHAIN_DEPTH;
    localparam int ADDR_W = $clog2(DEPTH);

    state_t state_reg, state_next;

    logic [BKT_W-1:0]    clr_reg;
    logic                cmd_reg;
    logic [ENTRY_W-1:0]  pair_reg;
    logic [ADDR_W-1:0]   base_reg;
    logic [FILL_W-1:0]   scan_reg, scan_next;
    logic [FILL_W-1:0]   scan_inc;

    logic                accept;
    logic                hash_done;
    logic [BKT_W-1:0]    hash_bucket;

    // bucket fill counts
    logic [FILL_W-1:0]   fill_mem [BUCKETS];
    logic [FILL_W-1:0]   fill_q;
    logic                fill_we;
    logic [BKT_W-1:0]    fill_waddr;
    logic [FILL_W-1:0]   fill_wdata;

    // chain entries, key above value
    logic [ENTRY_W-1:0]  entry_mem [DEPTH];
    logic [ENTRY_W-1:0]  entry_q;
    logic                entry_we;
    logic [ADDR_W-1:0]   entry_waddr;
    logic [ADDR_W-1:0]   entry_raddr;

    logic                full;
    logic                match;
    logic                last;

    logic                done_reg, done_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [BKT_W-1:0]    bidx_reg;
    logic [FILL_W-1:0]   cidx_reg, cidx_next;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    cht_hash #(
        .BUCKETS (BUCKETS)
    ) u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (accept),
        .key    (key),
        .done   (hash_done),
        .bucket (hash_bucket)
    );

    always_ff @(posedge clk)
    begin
        if (fill_we)
        begin
            fill_mem[fill_waddr] <= fill_wdata;
        end
        fill_q <= fill_mem[hash_bucket];
    end

    always_ff @(posedge clk)
    begin
        if (entry_we)
        begin
            entry_mem[entry_waddr] <= pair_reg;
        end
        entry_q <= entry_mem[entry_raddr];
    end

    assign full     = (fill_q >= FILL_W'(CHAIN_DEPTH));
    assign match    = (entry_q == pair_reg);
    assign scan_inc = scan_reg + FILL_W'(1);
    assign last     = (scan_inc == fill_q);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == BKT_W'(BUCKETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (cmd_reg == CMD_QUERY && fill_q != '0)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (match || last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        fill_we     = 1'b0;
        fill_waddr  = hash_bucket;
        fill_wdata  = fill_q + FILL_W'(1);
        entry_we    = 1'b0;
        entry_waddr = base_reg + ADDR_W'(fill_q);
        entry_raddr = base_reg;
        scan_next   = scan_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        cidx_next   = cidx_reg;
        case (state_reg)
            S_CLEAR:
            begin
                fill_we    = 1'b1;
                fill_waddr = clr_reg;
                fill_wdata = '0;
            end
            S_DECIDE:
            begin
                scan_next = '0;
                if (cmd_reg == CMD_INSERT)
                begin
                    done_next = 1'b1;
                    if (full)
                    begin
                        status_next = ST_FULL;
                        cidx_next   = '0;
                    end
                    else
                    begin
                        fill_we     = 1'b1;
                        entry_we    = 1'b1;
                        status_next = ST_INSERTED;
                        cidx_next   = fill_q;
                    end
                end
                else if (fill_q == '0)
                begin
                    done_next   = 1'b1;
                    status_next = ST_EMPTY;
                    cidx_next   = '0;
                end
            end
            S_SCAN:
            begin
                // fetch the next entry while the current one is compared
                entry_raddr = base_reg + ADDR_W'(scan_inc);
                scan_next   = scan_inc;
                if (match)
                begin
                    done_next   = 1'b1;
                    status_next = ST_FOUND;
                    cidx_next   = scan_reg;
                end
                else if (last)
                begin
                    done_next   = 1'b1;
                    status_next = ST_ABSENT;
                    cidx_next   = '0;
                end
            end
            default:
            begin
                entry_raddr = base_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + BKT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= command;
            pair_reg <= {key, value};
        end
        if (state_reg == S_FILL)
        begin
            base_reg <= ADDR_W'(hash_bucket * CHAIN_DEPTH);
        end
        if (done_next)
        begin
            bidx_reg <= hash_bucket;
        end
        scan_reg   <= scan_next;
        status_reg <= status_next;
        cidx_reg   <= cidx_next;
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign bucket_index = BIDX_W'(bidx_reg);
    assign chain_index  = CIDX_W'(cidx_reg);

endmodule

`default_nettype wire

/* rtl/cht_checker.sv */
// port-level checks of the hash table and their bind
`default_nettype none

`include "chained_hash_table_macros.svh"

module cht_checker (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           start,
    input  wire                           busy,
    input  wire                           done,
    input  wire [cht_pkg::STATUS_W-1:0]   status,
    input  wire [cht_pkg::CIDX_W-1:0]     chain_index
);
    import cht_pkg::*;

    `CHT_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy, "busy not raised after accept")
    `CHT_ASSERT_NXT(a_no_fast_result, clk, rst_n, start && !busy, !done, "result right after accept")
    `CHT_ASSERT_NXT(a_single_strobe, clk, rst_n, done, !done, "result strobed twice in a row")
    `CHT_ASSERT_IMP(a_status_code, clk, rst_n, done, status == ST_INSERTED || status == ST_FULL || status == ST_FOUND || status == ST_EMPTY || status == ST_ABSENT, "unknown status code")
    `CHT_ASSERT_IMP(a_miss_pos_zero, clk, rst_n, done && (status == ST_FULL || status == ST_EMPTY || status == ST_ABSENT), chain_index == '0, "nonzero position on miss")

endmodule

bind chained_hash_table cht_checker u_cht_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .chain_index (chain_index)
);

`default_nettype wire

/* tb/tb_chained_hash_table.sv */
// self-checking testbench for the chained hash table, with a scoreboard that predicts each reply
module tb_chained_hash_table;
    timeunit 1ns;
    timeprecision 1ps;

    import cht_pkg::*;

    localparam int BUCKETS     = 20;
    localparam int CHAIN_DEPTH = 8;
    localparam int ITEM_COUNT  = 1550;
    localparam int CYCLE_LIMIT = 200000;

    class hash_table_scoreboard;
        typedef struct {
            logic [STATUS_W-1:0] status;
            logic [BIDX_W-1:0]   bucket;
            logic [CIDX_W-1:0]   pos;
        } reply_t;

        int                 fill [BUCKETS];
        logic [ENTRY_W-1:0] entries [BUCKETS*CHAIN_DEPTH];
        reply_t             pending [$];
        int                 failures;

        function new();
            failures = 0;
            foreach (fill[i])
                fill[i] = 0;
        endfunction

        function int bucket_of(logic signed [KEY_W-1:0] k);
            longint mag;
            mag = k;
            if (mag < 0)
                mag = -mag;
            return int'((mag * mag) % BUCKETS);
        endfunction

        // predict the reply of an accepted item and update the table copy
        function void note_item(logic cmd, logic signed [KEY_W-1:0] k,
                                logic signed [VAL_W-1:0] v);
            reply_t             r;
            int                 b;
            logic [ENTRY_W-1:0] e;
            e        = {k, v};
            b        = bucket_of(k);
            r.bucket = BIDX_W'(b);
            r.pos    = '0;
            if (cmd == CMD_INSERT)
            begin
                if (fill[b] >= CHAIN_DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    entries[b*CHAIN_DEPTH + fill[b]] = e;
                    r.pos    = CIDX_W'(fill[b]);
                    fill[b]  = fill[b] + 1;
                    r.status = ST_INSERTED;
                end
            end
            else if (fill[b] == 0)
            begin
                r.status = ST_EMPTY;
            end
            else
            begin
                r.status = ST_ABSENT;
                // lowest matching position wins
                for (int slot = 0; slot < fill[b]; slot++)
                begin
                    if (entries[b*CHAIN_DEPTH + slot] == e)
                    begin
                        r.status = ST_FOUND;
                        r.pos    = CIDX_W'(slot);
                        break;
                    end
                end
            end
            pending = {pending, r};
        endfunction

        function void check_result(logic [STATUS_W-1:0] st, logic [BIDX_W-1:0] bkt,
                                   logic [CIDX_W-1:0] pos);
            reply_t r;
            if (pending.size() == 0)
            begin
                $error("result with no item outstanding: status %0d bucket %0d chain %0d",
                       st, bkt, pos);
                failures++;
                return;
            end
            r = pending.pop_front();
            if (st !== r.status)
            begin
                $error("status: expected %0d, got %0d", r.status, st);
                failures++;
            end
            if (bkt !== r.bucket)
            begin
                $error("bucket_index: expected %0d, got %0d", r.bucket, bkt);
                failures++;
            end
            if (pos !== r.pos)
            begin
                $error("chain_index: expected %0d, got %0d", r.pos, pos);
                failures++;
            end
        endfunction
    endclass

    typedef struct {
        logic signed [KEY_W-1:0] k;
        logic signed [VAL_W-1:0] v;
    } pair_t;

    logic                    clk     = 1'b0;
    logic                    rst_n   = 1'b0;
    logic                    start   = 1'b0;
    logic                    command = CMD_INSERT;
    logic signed [KEY_W-1:0] key     = '0;
    logic signed [VAL_W-1:0] value   = '0;
    logic                    busy;
    logic                    done;
    logic [STATUS_W-1:0]     status;
    logic [BIDX_W-1:0]       bucket_index;
    logic [CIDX_W-1:0]       chain_index;

    hash_table_scoreboard sb;
    pair_t                stored_pairs [$];
    bit                   allow_idle;
    int                   cycles = 0;

    chained_hash_table #(
        .BUCKETS     (BUCKETS),
        .CHAIN_DEPTH (CHAIN_DEPTH)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .key          (key),
        .value        (value),
        .done         (done),
        .status       (status),
        .bucket_index (bucket_index),
        .chain_index  (chain_index)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(status, bucket_index, chain_index);
            if (start && !busy)
                sb.note_item(command, key, value);
        end
    end

    // hold the item until the block takes it, dropping start on random cycles
    task automatic send_item(input logic c, input logic signed [KEY_W-1:0] k,
                             input logic signed [VAL_W-1:0] v);
        pair_t p;
        bit    idle;
        command <= c;
        key     <= k;
        value   <= v;
        forever
        begin
            idle = allow_idle && ($urandom_range(99) < 17);
            start <= !idle;
            @(posedge clk);
            if (!idle && !busy)
                break;
        end
        if (c == CMD_INSERT)
        begin
            p.k = k;
            p.v = v;
            stored_pairs = {stored_pairs, p};
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending.size() != 0);
    endtask

    task automatic random_item();
        pair_t p;
        int    r;
        r = $urandom_range(99);
        if (r < 30 || stored_pairs.size() == 0)
        begin
            send_item(r < 30 ? CMD_INSERT : CMD_QUERY, KEY_W'($urandom), $urandom);
        end
        else
        begin
            p = stored_pairs[$urandom_range(stored_pairs.size() - 1)];
            if (r < 70)
                send_item(CMD_QUERY, p.k, p.v);
            else if (r < 85)
                // known key, most likely a missing pair
                send_item(CMD_QUERY, p.k, $urandom);
            else
                send_item(CMD_QUERY, KEY_W'($urandom), $urandom);
        end
    endtask

    initial
    begin
        sb         = new();
        allow_idle = 1'b1;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty buckets, extreme keys and values
        send_item(CMD_QUERY,  16'sh0000, 32'sh00000000);
        send_item(CMD_QUERY,  16'sh8000, 32'sh80000000);
        send_item(CMD_QUERY,  -16'sd1,   -32'sd1);
        send_item(CMD_INSERT, 16'sh7fff, 32'sh7fffffff);
        send_item(CMD_INSERT, 16'sh8000, 32'sh80000000);
        send_item(CMD_QUERY,  16'sh7fff, 32'sh7fffffff);
        send_item(CMD_QUERY,  16'sh8000, 32'sh80000000);
        send_item(CMD_QUERY,  16'sh7fff, 32'sh00000000);
        // collisions in bucket zero, a duplicate pair, then fill it up
        send_item(CMD_INSERT, 16'sd0,   32'sd0);
        send_item(CMD_INSERT, 16'sd10,  -32'sd1);
        send_item(CMD_INSERT, -16'sd10, -32'sd1);
        send_item(CMD_INSERT, 16'sd0,   32'sd0);
        send_item(CMD_QUERY,  16'sd0,   32'sd0);
        send_item(CMD_QUERY,  -16'sd10, -32'sd1);
        send_item(CMD_QUERY,  16'sd10,  -32'sd1);
        for (int n = 2; n <= 6; n++)
            send_item(CMD_INSERT, KEY_W'(n * 10), VAL_W'(n));
        send_item(CMD_QUERY, 16'sd50, 32'sd5);
        send_item(CMD_QUERY, 16'sd50, 32'sd6);
        drain();

        for (int n = 0; n < ITEM_COUNT; n++)
        begin
            allow_idle = !(n >= 400 && n < 700);
            if (n == 1000)
                drain();
            random_item();
        end

        drain();
        repeat (20)
            @(posedge clk);
        if (sb.pending.size() != 0)
        begin
            $error("%0d expected results never arrived", sb.pending.size());
            sb.failures++;
        end
        if (sb.failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/cht_pkg.sv
rtl/cht_hash.sv
rtl/chained_hash_table.sv
rtl/cht_checker.sv
tb/tb_chained_hash_table.sv
